// ===== src/pctd_pkg.sv =====
// Shared types and constants of the prefix code table decoder.
`timescale 1ns / 1ps

package pctd_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Message byte codes
    localparam logic [7:0] SYM_ZERO     = 8'h67;  // 'g'
    localparam logic [7:0] SYM_ONE      = 8'h47;  // 'G'
    localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;  // '?'

    localparam int ENTRY_LEN_W  = 4;
    localparam int ENTRY_CODE_W = 9;
    localparam int CHAR_W       = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_CHECK
    } seq_state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } result_t;

endpackage

// ===== src/pctd_table.sv =====
// Code table memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module pctd_table #(
    parameter int ADDR_W = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [pctd_pkg::CHAR_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [pctd_pkg::CHAR_W-1:0] rd_data,
    output logic                       busy
);

    logic [pctd_pkg::CHAR_W-1:0] mem [2**ADDR_W];
    logic [pctd_pkg::CHAR_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]           clr_addr_reg;
    logic                        clr_busy_reg;

    // Sweep every entry to zero, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

// ===== src/pctd_out.sv =====
// Output register slice for result transfers.
`timescale 1ns / 1ps

module pctd_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  pctd_pkg::result_t           push_data,
    output logic                        push_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pctd_pkg::CHAR_W-1:0] m_out_char,
    output logic                        m_last
);

    logic              valid_reg;
    pctd_pkg::result_t data_reg;

    assign push_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_char = data_reg.out_char;
    assign m_last     = data_reg.last;

endmodule

// ===== src/pctd_seq.sv =====
// Sequencer: held symbols, table lookups, unknown-code rescans, result staging.
`timescale 1ns / 1ps

module pctd_seq #(
    parameter int CODE_LEN_LIMIT = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic [pctd_pkg::ENTRY_LEN_W-1:0]    s_entry_length,
    input  logic [pctd_pkg::ENTRY_CODE_W-1:0]   s_entry_code,
    input  logic [pctd_pkg::CHAR_W-1:0]         s_entry_value,
    input  logic [pctd_pkg::CHAR_W-1:0]         s_message_char,
    input  logic                                table_busy,
    output logic                                wr_en,
    output logic [CODE_LEN_LIMIT-1:0]           wr_addr,
    output logic [pctd_pkg::CHAR_W-1:0]         wr_data,
    output logic                                rd_en,
    output logic [CODE_LEN_LIMIT-1:0]           rd_addr,
    input  logic [pctd_pkg::CHAR_W-1:0]         rd_data,
    output logic                                push,
    output pctd_pkg::result_t                   push_data,
    input  logic                                push_ready
);

    localparam int ADDR_W  = CODE_LEN_LIMIT;
    localparam int MAX_LEN = CODE_LEN_LIMIT - 1;
    localparam int HB_W    = MAX_LEN;
    localparam int CNT_W   = $clog2(CODE_LEN_LIMIT);

    // Table index of the first n held symbols
    function automatic logic [ADDR_W-1:0] prefix_index(input logic [HB_W-1:0] bits,
                                                      input logic [CNT_W-1:0] n);
        logic [ADDR_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < HB_W; i++) begin
            idx[i] = (i < int'(n)) ? bits[i] : 1'b0;
        end
        idx = idx | (ADDR_W'(1) << n);
        return idx;
    endfunction

    pctd_pkg::seq_state_t        state_reg, state_next;
    logic [HB_W-1:0]             cbits_reg, cbits_next;
    logic [CNT_W-1:0]            ccount_reg, ccount_next;
    logic [CNT_W-1:0]            hcount_reg, hcount_next;
    logic                        push_mode_reg, push_mode_next;
    logic                        char_pend_reg, char_pend_next;
    logic [pctd_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                        stage_valid_reg, stage_valid_next;
    logic [pctd_pkg::CHAR_W-1:0] stage_char_reg, stage_char_next;

    logic                        emit_req;
    logic [pctd_pkg::CHAR_W-1:0] emit_char;
    logic                        emit_ok;
    logic                        sym_bit;
    logic [HB_W-1:0]             new_bits;
    logic                        wr_ok;
    logic                        resolve;
    logic [31:0]                 wr_index;

    assign emit_ok = !stage_valid_reg || push_ready;
    assign sym_bit = (s_message_char == pctd_pkg::SYM_ONE);
    assign new_bits = cbits_reg | (HB_W'(sym_bit) << ccount_reg);
    assign wr_ok = (s_entry_length != '0)
                && (32'(s_entry_length) <= MAX_LEN)
                && ((s_entry_code >> s_entry_length) == '0);
    assign wr_index = (32'd1 << s_entry_length) | 32'(s_entry_code);
    assign resolve = (ccount_reg >= CNT_W'(MAX_LEN))
                  || (!push_mode_reg && ccount_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pctd_pkg::ST_CLEAR;
            cbits_reg       <= '0;
            ccount_reg      <= '0;
            hcount_reg      <= '0;
            push_mode_reg   <= 1'b0;
            char_pend_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cbits_reg       <= cbits_next;
            ccount_reg      <= ccount_next;
            hcount_reg      <= hcount_next;
            push_mode_reg   <= push_mode_next;
            char_pend_reg   <= char_pend_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg       <= char_next;
        stage_char_reg <= stage_char_next;
    end

    always_comb begin
        state_next       = state_reg;
        cbits_next       = cbits_reg;
        ccount_next      = ccount_reg;
        hcount_next      = hcount_reg;
        push_mode_next   = push_mode_reg;
        char_pend_next   = char_pend_reg;
        char_next        = char_reg;
        stage_valid_next = stage_valid_reg;
        stage_char_next  = stage_char_reg;
        s_ready          = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = ADDR_W'(wr_index);
        wr_data          = s_entry_value;
        rd_en            = 1'b0;
        rd_addr          = prefix_index(cbits_reg, hcount_reg + 1'b1);
        push             = 1'b0;
        push_data        = '{out_char: stage_char_reg, last: 1'b0};
        emit_req         = 1'b0;
        emit_char        = rd_data;

        unique case (state_reg)
            pctd_pkg::ST_CLEAR: begin
                if (!table_busy) begin
                    state_next = pctd_pkg::ST_IDLE;
                end
            end

            pctd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_kind)
                        pctd_pkg::KIND_WRITE: begin
                            wr_en = wr_ok;
                        end
                        pctd_pkg::KIND_CHAR: begin
                            if (s_message_char == pctd_pkg::SYM_ZERO
                                || s_message_char == pctd_pkg::SYM_ONE) begin
                                // Append the symbol and look up the grown prefix at once
                                cbits_next     = new_bits;
                                ccount_next    = ccount_reg + 1'b1;
                                hcount_next    = ccount_reg + 1'b1;
                                rd_en          = 1'b1;
                                rd_addr        = prefix_index(new_bits, ccount_reg + 1'b1);
                                push_mode_next = 1'b1;
                                char_pend_next = 1'b0;
                                state_next     = pctd_pkg::ST_CHECK;
                            end else begin
                                push_mode_next = 1'b0;
                                char_pend_next = 1'b1;
                                char_next      = s_message_char;
                                state_next     = pctd_pkg::ST_STEP;
                            end
                        end
                        pctd_pkg::KIND_END: begin
                            push_mode_next = 1'b0;
                            char_pend_next = 1'b0;
                            state_next     = pctd_pkg::ST_STEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            pctd_pkg::ST_STEP: begin
                if (hcount_reg < ccount_reg) begin
                    // Feed the next pending symbol
                    rd_en       = 1'b1;
                    hcount_next = hcount_reg + 1'b1;
                    state_next  = pctd_pkg::ST_CHECK;
                end else if (resolve) begin
                    // Unknown run: emit '?', drop the first symbol, rescan the rest
                    emit_req  = 1'b1;
                    emit_char = pctd_pkg::UNKNOWN_CHAR;
                    if (emit_ok) begin
                        cbits_next  = cbits_reg >> 1;
                        ccount_next = ccount_reg - 1'b1;
                        hcount_next = '0;
                    end
                end else if (char_pend_reg) begin
                    emit_req  = 1'b1;
                    emit_char = char_reg;
                    if (emit_ok) begin
                        char_pend_next = 1'b0;
                    end
                end else if (stage_valid_reg) begin
                    // Release the final result of the item
                    push_data.last = 1'b1;
                    if (push_ready) begin
                        push             = 1'b1;
                        stage_valid_next = 1'b0;
                        state_next       = pctd_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = pctd_pkg::ST_IDLE;
                end
            end

            pctd_pkg::ST_CHECK: begin
                if (rd_data != '0) begin
                    emit_req  = 1'b1;
                    emit_char = rd_data;
                    if (emit_ok) begin
                        cbits_next  = cbits_reg >> hcount_reg;
                        ccount_next = ccount_reg - hcount_reg;
                        hcount_next = '0;
                        state_next  = pctd_pkg::ST_STEP;
                    end
                end else if ((hcount_reg < ccount_reg) || resolve || char_pend_reg
                             || stage_valid_reg) begin
                    state_next = pctd_pkg::ST_STEP;
                end else begin
                    state_next = pctd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pctd_pkg::ST_CLEAR;
            end
        endcase

        // Stage the new result; the older one leaves as not last
        if (emit_req && emit_ok) begin
            push             = stage_valid_reg;
            push_data.last   = 1'b0;
            stage_valid_next = 1'b1;
            stage_char_next  = emit_char;
        end
    end

endmodule

// ===== src/prefix_code_table_decoder.sv =====
// Top level of the prefix code table decoder.
`timescale 1ns / 1ps
// A table write is done when it is accepted; a code symbol with no match is accepted,
// then the table read returns; a match then stages its result before the output transfer.
// Flushes and rescans take each rescanned symbol through its own table lookup and emit
// one '?' per unknown run. Throughput: one item at a time.
// Reset: synchronous active-low aresetn clears control state, then all 2**CODE_LEN_LIMIT
// table entries (1024 by default) are swept to zero, one per cycle, with s_ready low.

module prefix_code_table_decoder #(
    parameter int CODE_LEN_LIMIT = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [pctd_pkg::ENTRY_LEN_W-1:0]  s_entry_length,
    input  logic [pctd_pkg::ENTRY_CODE_W-1:0] s_entry_code,
    input  logic [pctd_pkg::CHAR_W-1:0]       s_entry_value,
    input  logic [pctd_pkg::CHAR_W-1:0]       s_message_char,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pctd_pkg::CHAR_W-1:0]       m_out_char,
    output logic                              m_last
);

    // Table port between the sequencer and the memory
    logic                        wr_en;
    logic [CODE_LEN_LIMIT-1:0]   wr_addr;
    logic [pctd_pkg::CHAR_W-1:0] wr_data;
    logic                        rd_en;
    logic [CODE_LEN_LIMIT-1:0]   rd_addr;
    logic [pctd_pkg::CHAR_W-1:0] rd_data;
    logic                        table_busy;

    // Result path from the sequencer's staging register to the output slice
    logic                        push;
    pctd_pkg::result_t           push_data;
    logic                        push_ready;

    // Code table: entry for length L and code c sits at (1 << L) | c
    pctd_table #(
        .ADDR_W (CODE_LEN_LIMIT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (table_busy)
    );

    // Hold code symbols, look up each prefix, resolve unknown runs by rescanning
    pctd_seq #(
        .CODE_LEN_LIMIT (CODE_LEN_LIMIT)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_entry_length (s_entry_length),
        .s_entry_code   (s_entry_code),
        .s_entry_value  (s_entry_value),
        .s_message_char (s_message_char),
        .table_busy     (table_busy),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .push           (push),
        .push_data      (push_data),
        .push_ready     (push_ready)
    );

    // Output register: a finished result waits here while work goes on
    pctd_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

// ===== sim/pctd_result_checker.sv =====
// Scoreboard for the prefix code table decoder: predicts and checks every output transfer.
`timescale 1ns / 1ps

module pctd_result_checker #(
    parameter int CODE_LEN_LIMIT = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [pctd_pkg::ENTRY_LEN_W-1:0]  s_entry_length,
    input  logic [pctd_pkg::ENTRY_CODE_W-1:0] s_entry_code,
    input  logic [pctd_pkg::CHAR_W-1:0]       s_entry_value,
    input  logic [pctd_pkg::CHAR_W-1:0]       s_message_char,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [pctd_pkg::CHAR_W-1:0]       m_out_char,
    input  logic                              m_last,
    output int                                fail_count,
    output int                                pending
);

    localparam int TABLE_DEPTH  = 1 << CODE_LEN_LIMIT;
    localparam int MAX_CODE_LEN = CODE_LEN_LIMIT - 1;
    localparam int RESULT_CAP   = CODE_LEN_LIMIT + 6;

    logic [pctd_pkg::CHAR_W-1:0] code_mem [TABLE_DEPTH];
    logic [15:0]                 held_bits;
    int                          held_count;
    logic [pctd_pkg::CHAR_W-1:0] item_chars [$];
    pctd_pkg::result_t           expected_chars [$];
    int                          errors;

    function automatic logic [pctd_pkg::CHAR_W-1:0] table_read(int len, logic [15:0] bits);
        int idx;
        idx = ((1 << len) | (int'(bits) & ((1 << len) - 1))) & (TABLE_DEPTH - 1);
        return code_mem[idx];
    endfunction

    function automatic void emit_char(logic [pctd_pkg::CHAR_W-1:0] c);
        if (item_chars.size() < RESULT_CAP) begin
            item_chars.push_back(c);
        end
    endfunction

    // Append one symbol; a non-empty entry for the whole held run ends the code.
    function automatic void take_symbol(logic sym);
        logic [pctd_pkg::CHAR_W-1:0] hit;
        if (held_count >= 16) begin
            return;
        end
        held_bits[held_count] = sym;
        held_count++;
        hit = table_read(held_count, held_bits);
        if (hit != '0) begin
            emit_char(hit);
            held_bits  = '0;
            held_count = 0;
        end
    endfunction

    // Unknown run: emit '?', drop the first symbol, rescan what is left.
    function automatic void resolve_unknown();
        logic [15:0] rest;
        int          n;
        rest = held_bits >> 1;
        n    = held_count - 1;
        emit_char(pctd_pkg::UNKNOWN_CHAR);
        held_bits  = '0;
        held_count = 0;
        for (int i = 0; i < n; i++) begin
            take_symbol(rest[i]);
        end
    endfunction

    function automatic void push_symbol(logic sym);
        take_symbol(sym);
        if (held_count >= MAX_CODE_LEN) begin
            resolve_unknown();
        end
    endfunction

    function automatic void flush_run();
        while (held_count > 0) begin
            resolve_unknown();
        end
    endfunction

    function automatic void decode_item(logic [1:0] kind,
                                        logic [pctd_pkg::ENTRY_LEN_W-1:0] len,
                                        logic [pctd_pkg::ENTRY_CODE_W-1:0] code,
                                        logic [pctd_pkg::CHAR_W-1:0] val,
                                        logic [pctd_pkg::CHAR_W-1:0] ch);
        int n;
        item_chars.delete();
        case (kind)
            pctd_pkg::KIND_WRITE: begin
                if (len >= 1 && len <= MAX_CODE_LEN && (code >> len) == 0) begin
                    code_mem[((1 << len) | int'(code)) & (TABLE_DEPTH - 1)] = val;
                end
            end
            pctd_pkg::KIND_CHAR: begin
                if (ch == pctd_pkg::SYM_ZERO) begin
                    push_symbol(1'b0);
                end else if (ch == pctd_pkg::SYM_ONE) begin
                    push_symbol(1'b1);
                end else begin
                    flush_run();
                    emit_char(ch);
                end
            end
            pctd_pkg::KIND_END: begin
                flush_run();
            end
            default: ;
        endcase
        n = item_chars.size();
        for (int i = 0; i < n; i++) begin
            expected_chars.push_back('{out_char: item_chars[i], last: (i == n - 1)});
        end
    endfunction

    always @(posedge aclk) begin
        pctd_pkg::result_t want;
        if (!aresetn) begin
            foreach (code_mem[i]) begin
                code_mem[i] = '0;
            end
            held_bits  = '0;
            held_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_item(s_kind, s_entry_length, s_entry_code, s_entry_value,
                            s_message_char);
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transfer: out_char %h last %b", m_out_char, m_last);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_out_char !== want.out_char) begin
                        $error("out_char: expected %h, actual %h", want.out_char, m_out_char);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_last);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_chars.size();
    end

endmodule

// ===== sim/tb_prefix_code_table_decoder.sv =====
// Testbench top for the prefix code table decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_prefix_code_table_decoder;

    localparam int         CODE_LEN_LIMIT = 10;
    localparam int         MAX_LEN        = CODE_LEN_LIMIT - 1;
    localparam int         LEN_W          = pctd_pkg::ENTRY_LEN_W;
    localparam int         CODE_W         = pctd_pkg::ENTRY_CODE_W;
    localparam int         CHR_W          = pctd_pkg::CHAR_W;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS   = 310;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         CYCLE_LIMIT    = 200_000;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [1:0]        s_kind         = pctd_pkg::KIND_WRITE;
    logic [LEN_W-1:0]  s_entry_length = '0;
    logic [CODE_W-1:0] s_entry_code   = '0;
    logic [CHR_W-1:0]  s_entry_value  = '0;
    logic [CHR_W-1:0]  s_message_char = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [CHR_W-1:0]  m_out_char;
    logic              m_last;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    // While set, the bench never idles: no gaps before input items, and m_ready held high.
    logic quiet  = 1'b0;

    always #5 aclk = ~aclk;

    prefix_code_table_decoder #(
        .CODE_LEN_LIMIT (CODE_LEN_LIMIT)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_entry_length (s_entry_length),
        .s_entry_code   (s_entry_code),
        .s_entry_value  (s_entry_value),
        .s_message_char (s_message_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_last         (m_last)
    );

    pctd_result_checker #(
        .CODE_LEN_LIMIT (CODE_LEN_LIMIT)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_entry_length (s_entry_length),
        .s_entry_code   (s_entry_code),
        .s_entry_value  (s_entry_value),
        .s_message_char (s_message_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Throttle the result channel: drop ready at random with a probability of 18 percent,
    // hold it high throughout the quiet stretch.
    always @(posedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Watchdog: the slowest correct run stays far below this count.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Present one item and hold it until the transfer. Valid stays high after
    // the transfer so the next item can follow back to back; an idle gap lowers
    // it first. Each path makes at most one assignment to s_valid per edge.
    task automatic send_item(logic [1:0] kind, logic [LEN_W-1:0] len,
                             logic [CODE_W-1:0] code, logic [CHR_W-1:0] val,
                             logic [CHR_W-1:0] ch);
        int gap;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 18) begin
                gap++;
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_entry_length <= len;
        s_entry_code   <= code;
        s_entry_value  <= val;
        s_message_char <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_entry(logic [LEN_W-1:0] len, logic [CODE_W-1:0] code,
                               logic [CHR_W-1:0] val);
        send_item(pctd_pkg::KIND_WRITE, len, code, val, CHR_W'($urandom));
    endtask

    // Unused fields carry random values so their bits toggle too.
    task automatic send_char(logic [CHR_W-1:0] ch);
        send_item(pctd_pkg::KIND_CHAR, LEN_W'($urandom), CODE_W'($urandom),
                  CHR_W'($urandom), ch);
    endtask

    task automatic send_end();
        send_item(pctd_pkg::KIND_END, LEN_W'($urandom), CODE_W'($urandom),
                  CHR_W'($urandom), CHR_W'($urandom));
    endtask

    // Drop valid, hold off until every expected character has come out, then
    // give the block time to finish work that produces no output.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly code symbols, so codes build up, match, overrun and rescan; table
    // writes favor short codes so prefixes hit often. The first items fill the
    // table before the message symbols start.
    task automatic random_item(int idx);
        int                pick;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        pick = $urandom_range(99);
        if (idx < 10 || pick < 12) begin
            len  = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(MAX_LEN, 1))
                                            : LEN_W'($urandom_range(4, 1));
            code = CODE_W'($urandom) & CODE_W'((1 << len) - 1);
            write_entry(len, code, ($urandom_range(9) == 0) ? 8'h00
                                                            : CHR_W'($urandom_range(255, 1)));
        end else if (pick < 15) begin
            // Mostly malformed writes: bad length or code wider than its length.
            write_entry(LEN_W'($urandom), CODE_W'($urandom), CHR_W'($urandom));
        end else if (pick < 78) begin
            send_char($urandom_range(1) ? pctd_pkg::SYM_ONE : pctd_pkg::SYM_ZERO);
        end else if (pick < 88) begin
            send_char(CHR_W'($urandom));
        end else if (pick < 97) begin
            send_end();
        end else begin
            send_item(KIND_UNUSED, LEN_W'($urandom), CODE_W'($urandom),
                      CHR_W'($urandom), CHR_W'($urandom));
        end
    endtask

    initial begin
        // Hold reset, then release; the block sweeps its table with s_ready low,
        // and the first transfer simply waits for that.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: table write edges.
        write_entry(4'd1, 9'd0, 8'h65);                    // 'g' -> 'e'
        write_entry(4'd9, 9'h1FF, 8'hFF);                  // longest code, top value
        write_entry(4'd0, 9'd0, 8'h78);                    // zero length, ignored
        write_entry(4'd15, 9'h1FF, 8'h79);                 // widest length field, ignored
        write_entry(LEN_W'(CODE_LEN_LIMIT), 9'd0, 8'h7A);  // length at limit, ignored
        write_entry(4'd3, 9'd8, 8'h77);                    // code too wide, ignored

        // One-symbol code, then a write while a symbol is held.
        send_char(pctd_pkg::SYM_ZERO);
        send_char(pctd_pkg::SYM_ONE);
        write_entry(4'd2, 9'd1, 8'h74);                    // 'Gg' -> 't'
        send_char(pctd_pkg::SYM_ZERO);

        // Plain byte flushes a held symbol, then passes through; both byte extremes.
        send_char(pctd_pkg::SYM_ONE);
        send_char(8'hFF);
        send_char(8'h00);

        // End with nothing held and the unused kind: no output expected.
        send_end();
        send_item(KIND_UNUSED, '1, '1, '1, '1);

        // Overlong code, then an end that flushes a long held run.
        repeat (8) send_char(pctd_pkg::SYM_ONE);
        send_char(pctd_pkg::SYM_ZERO);
        send_end();

        wait_drained();

        // Random part with a quiet stretch and one more full drain midway.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 60) begin
                quiet <= 1'b1;
            end
            if (i == 140) begin
                quiet <= 1'b0;
            end
            if (i == 150) begin
                wait_drained();
            end
            random_item(i);
        end

        wait_drained();

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pctd_pkg.sv
src/pctd_table.sv
src/pctd_out.sv
src/pctd_seq.sv
src/prefix_code_table_decoder.sv
sim/pctd_result_checker.sv
sim/tb_prefix_code_table_decoder.sv
